// ===== hdl/jrl_pkg.sv =====
// Package: shared constants, types and helpers for the job resource ledger.
`default_nettype none
package jrl_pkg;
   localparam int Entries = 64;
   localparam int SlotW = $clog2(Entries);
   localparam int CntW = SlotW + 1;

   typedef enum logic [1:0] {
      KIND_ASSIGN  = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_DROP    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   localparam logic [1:0] RES_CPU = 2'd0;
   localparam logic [1:0] RES_GPU = 2'd1;
   localparam logic [1:0] RES_MEM = 2'd2;
   localparam logic [1:0] RES_BAD = 2'd3;

   localparam logic [2:0] ST_UPDATED  = 3'd0;
   localparam logic [2:0] ST_CREATED  = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_BADRES   = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_FREED    = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_WRITE,
      S_EMIT,
      S_DROP_RD,
      S_DROP_ACC,
      S_DROP_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       scan_clr;
      logic       scan_step;
      logic       rd;
      logic       wr;
      logic       drop_step;
      logic [1:0] drop_res;
      logic       emit_single;
      logic       emit_drop;
   } cmd_type;

   typedef struct packed {
      logic       scan_done;
      logic [1:0] kind;
      logic       drop_done;
      logic [2:0] drop_nz;
      logic       out_busy;
   } sts_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage
`default_nettype wire

// ===== hdl/jrl_datapath.sv =====
// Datapath: slot store, key search, read-modify-write, drop sweep and output register.
`default_nettype none
module jrl_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jrl_pkg::cmd_type   cmd,
   output jrl_pkg::sts_type        sts,
   input  wire logic [1:0]         in_kind,
   input  wire logic [30:0]        in_job,
   input  wire logic [9:0]         in_conn,
   input  wire logic [1:0]         in_res,
   input  wire logic [15:0]        in_amt,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [31:0]             out_quantity,
   output logic [1:0]              out_res_code,
   output logic [2:0]              out_status,
   output logic                    out_last
);
   localparam int N = jrl_pkg::Entries;
   localparam int SW = jrl_pkg::SlotW;
   localparam int CW = jrl_pkg::CntW;

   logic [N-1:0] valid_ff, valid_in;
   logic [30:0]  job_mem [N];
   logic [9:0]   conn_mem [N];
   logic [31:0]  cpu_mem [N];
   logic [31:0]  gpu_mem [N];
   logic [31:0]  mem_mem [N];

   logic [1:0]  kind_ff;
   logic [30:0] job_ff;
   logic [9:0]  conn_ff;
   logic [1:0]  res_ff;
   logic [15:0] amt_ff;

   logic [CW-1:0] idx_ff, idx_in;
   logic          hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [SW-1:0] hit_slot_ff, hit_slot_in, free_slot_ff, free_slot_in;

   logic [30:0] rd_job;
   logic [9:0]  rd_conn;
   logic [31:0] rd_cpu, rd_gpu, rd_mem;
   logic        rd_vld_ff;
   logic [31:0] tot_ff [3];
   logic [SW-1:0] slot;
   logic [SW-1:0] rd_slot_ff;

   logic        ovalid_ff;
   logic [31:0] oq_ff;
   logic [1:0]  orc_ff;
   logic [2:0]  ost_ff;
   logic        olast_ff;

   logic        good;
   logic [31:0] held, rel, newv, ncpu, ngpu, nmem;
   logic [2:0]  single_st;
   logic [31:0] single_q;
   logic [1:0]  single_rc;

   assign slot = hit_ff ? hit_slot_ff : free_slot_ff;
   assign good = (res_ff != jrl_pkg::RES_BAD);

   // sequential search, one slot per cycle; read data is registered and trails the index
   always_comb begin
      idx_in = idx_ff;
      hit_in = hit_ff;
      hit_slot_in = hit_slot_ff;
      free_ok_in = free_ok_ff;
      free_slot_in = free_slot_ff;
      if (cmd.scan_clr) begin
         idx_in = '0;
         hit_in = 1'b0;
         free_ok_in = 1'b0;
      end else if (cmd.scan_step || cmd.drop_step) begin
         if (cmd.scan_step && idx_ff != '0) begin
            if (rd_vld_ff && rd_job == job_ff && !hit_ff) begin
               hit_in = 1'b1;
               hit_slot_in = rd_slot_ff;
            end
            if (!rd_vld_ff && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_slot_in = rd_slot_ff;
            end
         end
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         hit_ff <= hit_in;
         free_ok_ff <= free_ok_in;
      end
      hit_slot_ff <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      if (cmd.load) begin
         kind_ff <= in_kind;
         job_ff <= in_job;
         conn_ff <= in_conn;
         res_ff <= in_res;
         amt_ff <= in_amt;
      end
   end

   // registered reads of all columns
   always_ff @(posedge clock) begin
      rd_slot_ff <= cmd.rd ? slot : idx_ff[SW-1:0];
      rd_job <= job_mem[idx_ff[SW-1:0]];
      rd_conn <= conn_mem[cmd.rd ? slot : idx_ff[SW-1:0]];
      rd_cpu <= cpu_mem[cmd.rd ? slot : idx_ff[SW-1:0]];
      rd_gpu <= gpu_mem[cmd.rd ? slot : idx_ff[SW-1:0]];
      rd_mem <= mem_mem[cmd.rd ? slot : idx_ff[SW-1:0]];
      rd_vld_ff <= valid_ff[idx_ff[SW-1:0]];
   end

   always_comb begin
      ncpu = hit_ff ? rd_cpu : 32'd0;
      ngpu = hit_ff ? rd_gpu : 32'd0;
      nmem = hit_ff ? rd_mem : 32'd0;
      case (res_ff)
         jrl_pkg::RES_CPU: held = ncpu;
         jrl_pkg::RES_GPU: held = ngpu;
         default:          held = nmem;
      endcase
      rel = ({16'd0, amt_ff} > held) ? held : {16'd0, amt_ff};
      if (kind_ff == jrl_pkg::KIND_ASSIGN)
         newv = jrl_pkg::sat_add(held, {16'd0, amt_ff});
      else
         newv = held - rel;
      if (good) begin
         case (res_ff)
            jrl_pkg::RES_CPU: ncpu = newv;
            jrl_pkg::RES_GPU: ngpu = newv;
            default:          nmem = newv;
         endcase
      end
      single_q = 32'd0;
      single_rc = good ? res_ff : jrl_pkg::RES_CPU;
      if (kind_ff == jrl_pkg::KIND_ASSIGN) begin
         if (!hit_ff && !free_ok_ff) single_st = jrl_pkg::ST_FULL;
         else if (!good) single_st = jrl_pkg::ST_BADRES;
         else if (hit_ff) single_st = jrl_pkg::ST_UPDATED;
         else single_st = jrl_pkg::ST_CREATED;
      end else begin
         if (!hit_ff) begin
            single_st = jrl_pkg::ST_NOTFOUND;
            single_rc = jrl_pkg::RES_CPU;
         end else if (!good) begin
            single_st = jrl_pkg::ST_BADRES;
         end else begin
            single_q = rel;
            single_st = (ncpu == 0 && ngpu == 0 && nmem == 0) ?
                        jrl_pkg::ST_FREED : jrl_pkg::ST_UPDATED;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr) begin
         if (kind_ff == jrl_pkg::KIND_ASSIGN) begin
            if (hit_ff || free_ok_ff) valid_in[slot] = 1'b1;
         end else if (hit_ff && good && single_st == jrl_pkg::ST_FREED) begin
            valid_in[slot] = 1'b0;
         end
      end
      if (cmd.drop_step && rd_vld_ff && rd_conn == conn_ff && idx_ff != '0)
         valid_in[rd_slot_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
      if (cmd.wr && (hit_ff || free_ok_ff) &&
          (kind_ff == jrl_pkg::KIND_ASSIGN || good)) begin
         job_mem[slot] <= job_ff;
         if (!hit_ff) conn_mem[slot] <= conn_ff;
         cpu_mem[slot] <= ncpu;
         gpu_mem[slot] <= ngpu;
         mem_mem[slot] <= nmem;
      end
   end

   // drop sweep accumulators; read data is registered and trails the index
   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         tot_ff[0] <= 32'd0;
         tot_ff[1] <= 32'd0;
         tot_ff[2] <= 32'd0;
      end else if (cmd.drop_step && idx_ff != '0 && rd_vld_ff && rd_conn == conn_ff) begin
         tot_ff[0] <= jrl_pkg::sat_add(tot_ff[0], rd_cpu);
         tot_ff[1] <= jrl_pkg::sat_add(tot_ff[1], rd_gpu);
         tot_ff[2] <= jrl_pkg::sat_add(tot_ff[2], rd_mem);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.emit_single || cmd.emit_drop) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
      if (cmd.emit_single) begin
         oq_ff <= single_q;
         orc_ff <= single_rc;
         ost_ff <= single_st;
         olast_ff <= 1'b1;
      end else if (cmd.emit_drop) begin
         oq_ff <= tot_ff[cmd.drop_res];
         orc_ff <= cmd.drop_res;
         ost_ff <= jrl_pkg::ST_FREED;
         case (cmd.drop_res)
            jrl_pkg::RES_CPU: olast_ff <= (tot_ff[1] == 0 && tot_ff[2] == 0);
            jrl_pkg::RES_GPU: olast_ff <= (tot_ff[2] == 0);
            default:          olast_ff <= 1'b1;
         endcase
      end
   end

   assign out_valid = ovalid_ff;
   assign out_quantity = oq_ff;
   assign out_res_code = orc_ff;
   assign out_status = ost_ff;
   assign out_last = olast_ff;

   always_comb begin
      sts.scan_done = (idx_ff == CW'(N));
      sts.drop_done = (idx_ff == CW'(N));
      sts.kind = kind_ff;
      sts.drop_nz = {tot_ff[2] != 0, tot_ff[1] != 0, tot_ff[0] != 0};
      sts.out_busy = ovalid_ff && !out_ready;
   end

`ifndef NO_ASSERTIONS
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      $rose(ovalid_ff) && ost_ff != jrl_pkg::ST_FREED |-> olast_ff)
      else $error("single result without last");
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr && hit_ff |-> valid_ff[hit_slot_ff])
      else $error("hit slot not valid");
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.wr && !hit_ff && free_ok_ff |-> !valid_ff[free_slot_ff])
      else $error("free slot in use");
`endif
endmodule
`default_nettype wire

// ===== hdl/jrl_ctrl.sv =====
// Controller: sequences search, update, drop sweep and result emission.
`default_nettype none
module jrl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire jrl_pkg::sts_type sts,
   output jrl_pkg::cmd_type      cmd
);
   jrl_pkg::state_type state_ff, state_in;
   logic [1:0] dres_ff, dres_in;
   logic       pend_ff, pend_in;

   always_comb begin
      state_in = state_ff;
      dres_in = dres_ff;
      pend_in = pend_ff;
      case (state_ff)
         jrl_pkg::S_IDLE: begin
            if (in_valid && !sts.out_busy) state_in = jrl_pkg::S_SCAN;
         end
         jrl_pkg::S_SCAN: begin
            case (sts.kind)
               jrl_pkg::KIND_ASSIGN, jrl_pkg::KIND_RELEASE: begin
                  if (sts.scan_done && pend_ff) state_in = jrl_pkg::S_READ;
                  pend_in = 1'b1;
               end
               jrl_pkg::KIND_DROP: state_in = jrl_pkg::S_DROP_RD;
               default: state_in = jrl_pkg::S_IDLE;
            endcase
         end
         jrl_pkg::S_READ: begin
            pend_in = 1'b0;
            state_in = jrl_pkg::S_WRITE;
         end
         jrl_pkg::S_WRITE: state_in = jrl_pkg::S_IDLE;
         jrl_pkg::S_DROP_RD: begin
            if (sts.drop_done) state_in = jrl_pkg::S_DROP_ACC;
         end
         jrl_pkg::S_DROP_ACC: begin
            dres_in = jrl_pkg::RES_CPU;
            state_in = jrl_pkg::S_DROP_OUT;
         end
         jrl_pkg::S_DROP_OUT: begin
            if (!sts.out_busy) begin
               if (dres_ff == jrl_pkg::RES_MEM) state_in = jrl_pkg::S_IDLE;
               dres_in = dres_ff + 2'd1;
            end
         end
         default: state_in = jrl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      case (state_ff)
         jrl_pkg::S_IDLE: begin
            in_ready = !sts.out_busy;
            cmd.load = in_valid && !sts.out_busy;
            cmd.scan_clr = 1'b1;
         end
         jrl_pkg::S_SCAN: begin
            if (sts.kind == jrl_pkg::KIND_DROP) cmd.scan_clr = 1'b1;
            else if (pend_ff) cmd.scan_step = 1'b1;
            else cmd.scan_clr = 1'b1;
         end
         jrl_pkg::S_READ: cmd.rd = 1'b1;
         jrl_pkg::S_WRITE: begin
            cmd.wr = 1'b1;
            cmd.emit_single = 1'b1;
         end
         jrl_pkg::S_DROP_RD: cmd.drop_step = 1'b1;
         jrl_pkg::S_DROP_OUT: begin
            cmd.drop_res = dres_ff;
            cmd.emit_drop = !sts.out_busy && sts.drop_nz[dres_ff];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jrl_pkg::S_IDLE;
         dres_ff <= 2'd0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dres_ff <= dres_in;
         pend_ff <= pend_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> state_ff == jrl_pkg::S_IDLE)
      else $error("ready outside idle");
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_single && cmd.emit_drop))
      else $error("double emit");
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> $past(cmd.rd))
      else $error("write without read");
`endif
endmodule
`default_nettype wire

// ===== hdl/job_resource_ledger.sv =====
// Top level: job resource ledger with stream input and output.
// One item at a time. An assign or release takes a setup step, a search of
// the 64 slots (registered reads trail the slot index), a read and a write;
// its result is then offered, and the next input can be taken after it. A
// connection drop sweeps all slots and then offers up to three totals, one
// per cycle while the receiver is ready. Kind three gives no result. A result
// held by rsp_tready holds off the next input. The table search sets the
// rate.
`default_nettype none
module job_resource_ledger (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // job_key[30:0], connection[40:31], resource[42:41], amount[58:43]
   input  wire logic [63:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // quantity[31:0], res_code[33:32], status[36:34]
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);
   jrl_pkg::cmd_type cmd;
   jrl_pkg::sts_type sts;
   logic [31:0] q;
   logic [1:0]  rc;
   logic [2:0]  st;

   jrl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .sts(sts), .cmd(cmd)
   );

   jrl_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_kind(req_tuser), .in_job(req_tdata[30:0]), .in_conn(req_tdata[40:31]),
      .in_res(req_tdata[42:41]), .in_amt(req_tdata[58:43]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_quantity(q), .out_res_code(rc), .out_status(st), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {3'd0, st, rc, q};

`ifndef NO_ASSERTIONS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed under stall");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:37] == 3'd0)
      else $error("pad bits set");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("accept under output stall");
`endif
endmodule
`default_nettype wire
